// ===== rtl/euclidean_distance_unit_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euclidean distance unit
// Same-cycle/next-cycle implication checks, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_UNIT_CORE_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_UNIT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define EDU_ASSERT_IMP(lbl, aclk, arst_n, ante, cons, msg) \
  lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define EDU_ASSERT_NXT(lbl, aclk, arst_n, ante, cons, msg) \
  lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EDU_ASSERT_IMP(lbl, aclk, arst_n, ante, cons, msg)
`define EDU_ASSERT_NXT(lbl, aclk, arst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/edu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edu_pkg
// Widths, constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package edu_pkg;

  localparam int ELEM_W  = 16;              // Q8.8 element
  localparam int DIFF_W  = ELEM_W + 1;      // exact difference
  localparam int PROD_W  = 2 * DIFF_W;      // signed product width
  localparam int SQ_W    = 32;              // |diff|^2 < 2^32
  localparam int SUM_W   = 42;              // Q26.16 accumulator
  localparam int DIST_W  = SUM_W / 2;       // root bits
  localparam int REM_W   = DIST_W + 1;      // remainder <= 2*root
  localparam int CNT_W   = 5;
  localparam int ROOT_STEPS = DIST_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

  typedef struct packed {
    logic root_step;   // one digit of the square root
    logic res_load;    // load result register, clear vector state
  } edu_cmd_t;

  typedef struct packed {
    logic pipe_busy;   // squares still on their way to the accumulator
    logic out_free;    // result register can take a new result
  } edu_sts_t;

endpackage

// ===== rtl/edu_datapath.sv =====
`timescale 1ns / 1ps
`include "euclidean_distance_unit_core_defines.svh"
// ----------------------------------------------------------------------------
// edu_datapath
// Difference/square pipeline, saturating accumulator, digit-serial square
// root and result register.
// ----------------------------------------------------------------------------
module edu_datapath import edu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  logic [ELEM_W-1:0] element_a,
  input  logic [ELEM_W-1:0] element_b,
  input  logic              a_present,
  input  logic              b_present,
  input  edu_cmd_t          cmd,
  output edu_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DIST_W-1:0] distance,
  output logic              length_mismatch,
  output logic              sum_saturated
);

  logic                     s1_vld_r, s1_vld_nxt;
  logic signed [DIFF_W-1:0] s1_diff_r, s1_diff_nxt;
  logic                     s2_vld_r, s2_vld_nxt;
  logic [SQ_W-1:0]          s2_sq_r, s2_sq_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic                     mism_r, mism_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [DIST_W-1:0]        part_r, part_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [DIST_W-1:0]        out_dist_r, out_dist_nxt;
  logic                     out_mism_r, out_mism_nxt;
  logic                     out_sat_r, out_sat_nxt;

  logic signed [PROD_W-1:0] prod;
  logic [SUM_W:0]           acc_sum;
  logic [REM_W+1:0]         rem_sh;
  logic [REM_W+1:0]         trial;
  logic                     take;

  assign prod    = s1_diff_r * s1_diff_r;
  assign acc_sum = {1'b0, sum_r} + {{(SUM_W + 1 - SQ_W){1'b0}}, s2_sq_r};
  // next remainder digit pair comes from the top of the shifting sum
  assign rem_sh  = {rem_r, sum_r[SUM_W-1 -: 2]};
  assign trial   = {1'b0, part_r, 2'b01};
  assign take    = (rem_sh >= trial);

  always_comb begin
    s1_vld_nxt   = in_acc && a_present && b_present;
    s1_diff_nxt  = $signed({element_a[ELEM_W-1], element_a})
                 - $signed({element_b[ELEM_W-1], element_b});
    s2_vld_nxt   = s1_vld_r;
    s2_sq_nxt    = prod[SQ_W-1:0];
    sum_nxt      = sum_r;
    mism_nxt     = mism_r;
    ovf_nxt      = ovf_r;
    rem_nxt      = rem_r;
    part_nxt     = part_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_dist_nxt = out_dist_r;
    out_mism_nxt = out_mism_r;
    out_sat_nxt  = out_sat_r;

    if (in_acc && (a_present != b_present)) begin
      mism_nxt = 1'b1;
    end
    if (s2_vld_r) begin
      if (acc_sum[SUM_W]) begin
        sum_nxt = SUM_MAX;
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = acc_sum[SUM_W-1:0];
      end
    end
    if (cmd.root_step) begin
      sum_nxt  = {sum_r[SUM_W-3:0], 2'b00};
      rem_nxt  = take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      part_nxt = {part_r[DIST_W-2:0], take};
    end
    if (cmd.res_load) begin
      out_vld_nxt  = 1'b1;
      out_dist_nxt = mism_r ? '0 : part_r;
      out_mism_nxt = mism_r;
      out_sat_nxt  = ovf_r;
      sum_nxt      = '0;
      mism_nxt     = 1'b0;
      ovf_nxt      = 1'b0;
      rem_nxt      = '0;
      part_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      sum_r     <= '0;
      mism_r    <= 1'b0;
      ovf_r     <= 1'b0;
      rem_r     <= '0;
      part_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      sum_r     <= sum_nxt;
      mism_r    <= mism_nxt;
      ovf_r     <= ovf_nxt;
      rem_r     <= rem_nxt;
      part_r    <= part_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_diff_r  <= s1_diff_nxt;
    s2_sq_r    <= s2_sq_nxt;
    out_dist_r <= out_dist_nxt;
    out_mism_r <= out_mism_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign sts.pipe_busy  = s1_vld_r || s2_vld_r;
  assign sts.out_free   = !out_vld_r || out_ready;
  assign out_valid       = out_vld_r;
  assign distance        = out_dist_r;
  assign length_mismatch = out_mism_r;
  assign sum_saturated   = out_sat_r;

  `EDU_ASSERT_IMP(a_root_no_pending, clk, rst_n, cmd.root_step,
    !s1_vld_r && !s2_vld_r, "root step while squares still in flight")
  `EDU_ASSERT_NXT(a_load_clears, clk, rst_n, cmd.res_load,
    out_vld_r && rem_r == '0 && part_r == '0 && !mism_r && !ovf_r,
    "result load did not clear vector state")
  `EDU_ASSERT_IMP(a_mism_zero, clk, rst_n, out_vld_r && out_mism_r,
    out_dist_r == '0, "mismatch result with non-zero distance")

endmodule

// ===== rtl/edu_ctrl.sv =====
`timescale 1ns / 1ps
`include "euclidean_distance_unit_core_defines.svh"
// ----------------------------------------------------------------------------
// edu_ctrl
// Sequencer: accumulate, drain the square pipeline, run the root, hand over.
// ----------------------------------------------------------------------------
module edu_ctrl import edu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_acc,
  input  logic     in_last,
  input  edu_sts_t sts,
  output edu_cmd_t cmd,
  output logic     in_ready
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_ROOT,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.root_step = 1'b0;
    cmd.res_load  = 1'b0;
    case (state_r)
      ST_ACCUM: begin
        if (in_acc && in_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == ST_ACCUM);

  `EDU_ASSERT_IMP(a_load_has_room, clk, rst_n, cmd.res_load, sts.out_free,
    "result loaded over an untaken result")
  `EDU_ASSERT_NXT(a_root_ends, clk, rst_n, state_r == ST_ROOT && cnt_r == ROOT_LAST,
    state_r == ST_DONE && !cmd.root_step, "root ran past its last digit")
  `EDU_ASSERT_NXT(a_last_stops_input, clk, rst_n, in_acc && in_last,
    state_r == ST_FLUSH && !in_ready, "input still open after last transfer")

endmodule

// ===== rtl/euclidean_distance_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance_unit_core
// Streaming Euclidean distance of two Q8.8 vectors, result in unsigned Q13.8.
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer carries
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | one element pair, presence flags, end of vector
//  out_    | master    | distance, length mismatch, accumulator saturated
//
//  Non-last transfers are taken one per cycle, back to back.
//  After the last transfer of a vector in_tready drops while the block
//  drains the difference/square pipeline, runs the digit-serial root (one
//  result bit per cycle) and loads the result.
//  The result sits in its own register, so the next vector streams in while
//  it waits; input stalls beyond the drain and root only if that result is not yet taken.
//  rst_n is synchronous, active low, and empties the block.
//
module euclidean_distance_unit_core import edu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input element stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] element_a, [31:16] element_b
  input  logic [1:0]  in_tuser,   // [0] a_present, [1] b_present
  input  logic        in_tlast,   // last pair of the vectors
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] distance, [23:21] zero
  output logic [1:0]  out_tuser   // [0] length_mismatch, [1] sum_saturated
);

  edu_cmd_t          cmd;
  edu_sts_t          sts;
  logic              in_acc;
  logic [DIST_W-1:0] distance;
  logic              length_mismatch;
  logic              sum_saturated;

  // an input transfer completes on valid and ready together
  assign in_acc = in_tvalid && in_tready;

  edu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_last  (in_tlast),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  edu_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_acc          (in_acc),
    .element_a       (in_tdata[ELEM_W-1:0]),
    .element_b       (in_tdata[2*ELEM_W-1:ELEM_W]),
    .a_present       (in_tuser[0]),
    .b_present       (in_tuser[1]),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .distance        (distance),
    .length_mismatch (length_mismatch),
    .sum_saturated   (sum_saturated)
  );

  // pad distance to whole bytes
  assign out_tdata = {{(24 - DIST_W){1'b0}}, distance};
  assign out_tuser = {sum_saturated, length_mismatch};

endmodule
